/* hw/rtl/pid_positional_incremental_core_defines.svh */
// ============================================================================
// PID core assertion macros
// Shared concurrent assertion forms for the PID controller RTL.
// ============================================================================
`ifndef PID_POSITIONAL_INCREMENTAL_CORE_DEFINES_SVH
`define PID_POSITIONAL_INCREMENTAL_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PIDPI_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define PIDPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PIDPI_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)

`define PIDPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/pidpi_pkg.sv */
// ============================================================================
// PID core package
// Widths, payload and control types, register indexes and the clamp helper.
// ============================================================================
package pidpi_pkg;

    localparam int DW       = 16;
    localparam int EW       = DW + 1;
    localparam int GW       = 16;
    localparam int FRAC     = 8;
    localparam int BAND_W   = 16;
    localparam int LIM_W    = 15;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int P_OP_W   = EW + 1;
    localparam int D_OP_W   = EW + 2;
    localparam int P_W      = GW + P_OP_W - FRAC;
    localparam int I_W      = GW + EW - FRAC;
    localparam int D_W      = GW + D_OP_W - FRAC;
    localparam int IACC_W   = I_W + 1;
    localparam int SUM_W    = D_W + 2;

    localparam logic                     RST_MODE = 1'b0;
    localparam logic signed [GW-1:0]     RST_KP   = 16'sd256;
    localparam logic signed [GW-1:0]     RST_KI   = 16'sd0;
    localparam logic signed [GW-1:0]     RST_KD   = 16'sd0;
    localparam logic        [BAND_W-1:0] RST_BAND = 16'd1000;
    localparam logic        [LIM_W-1:0]  RST_ILIM = 15'd1000;
    localparam logic        [LIM_W-1:0]  RST_OLIM = 15'd1000;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE           = 3'd0,
        CFG_KP_GAIN        = 3'd1,
        CFG_KI_GAIN        = 3'd2,
        CFG_KD_GAIN        = 3'd3,
        CFG_INTEGRAL_BAND  = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5,
        CFG_OUTPUT_LIMIT   = 3'd6
    } t_cfg_idx;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic signed [DW-1:0] setpoint;
        logic signed [DW-1:0] measured;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic signed [DW-1:0] integral_term;
    } t_out;

    typedef struct packed {
        logic                     mode;
        logic signed [GW-1:0]     kp_gain;
        logic signed [GW-1:0]     ki_gain;
        logic signed [GW-1:0]     kd_gain;
        logic        [BAND_W-1:0] integral_band;
        logic        [LIM_W-1:0]  integral_limit;
        logic        [LIM_W-1:0]  output_limit;
    } t_cfg;

    typedef struct packed {
        logic s1_adv;
        logic s2_adv;
    } t_ctl;

    function automatic logic signed [DW-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] x,
        input logic        [LIM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [DW-1:0]    res;
        hi = $signed({{(SUM_W - LIM_W){1'b0}}, lim});
        lo = -hi;
        if (x > hi) begin
            res = hi[DW-1:0];
        end else if (x < lo) begin
            res = lo[DW-1:0];
        end else begin
            res = x[DW-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/pidpi_cfg_regs.sv */
// ============================================================================
// PID core configuration registers
// Write-only register file for mode, gains, integral band and limits.
// ============================================================================
module pidpi_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pidpi_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [pidpi_pkg::CFG_W-1:0] i_cfg_wdata,
    output pidpi_pkg::t_cfg          o_cfg
);
    import pidpi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= RST_MODE;
            r_cfg.kp_gain        <= RST_KP;
            r_cfg.ki_gain        <= RST_KI;
            r_cfg.kd_gain        <= RST_KD;
            r_cfg.integral_band  <= RST_BAND;
            r_cfg.integral_limit <= RST_ILIM;
            r_cfg.output_limit   <= RST_OLIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:           r_cfg.mode           <= i_cfg_wdata[0];
                CFG_KP_GAIN:        r_cfg.kp_gain        <= $signed(i_cfg_wdata[GW-1:0]);
                CFG_KI_GAIN:        r_cfg.ki_gain        <= $signed(i_cfg_wdata[GW-1:0]);
                CFG_KD_GAIN:        r_cfg.kd_gain        <= $signed(i_cfg_wdata[GW-1:0]);
                CFG_INTEGRAL_BAND:  r_cfg.integral_band  <= i_cfg_wdata[BAND_W-1:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_wdata[LIM_W-1:0];
                CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/pidpi_datapath.sv */
// ============================================================================
// PID core datapath
// Error and gain products in the first stage, integral update and drive
// clamp in the second stage, with the controller state kept alongside.
// ============================================================================
module pidpi_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pidpi_pkg::t_cfg i_cfg,
    input  pidpi_pkg::t_ctl i_ctl,
    input  pidpi_pkg::t_in  i_in,
    output pidpi_pkg::t_out o_out
);
    import pidpi_pkg::*;

    logic signed [EW-1:0]     r_prev_err;
    logic signed [EW-1:0]     r_pprev_err;
    logic signed [DW-1:0]     r_isum;
    logic signed [P_W-1:0]    r_p;
    logic signed [I_W-1:0]    r_i;
    logic signed [D_W-1:0]    r_d;
    logic                     r_active;
    t_out                     r_out;

    logic signed [EW-1:0]         err;
    logic        [EW-1:0]         abs_ms;
    logic                         active;
    logic signed [P_OP_W-1:0]     diff1;
    logic signed [D_OP_W-1:0]     diff2;
    logic signed [P_OP_W-1:0]     p_opnd;
    logic signed [D_OP_W-1:0]     d_opnd;
    logic signed [GW+P_OP_W-1:0]  p_prod;
    logic signed [GW+EW-1:0]      i_prod;
    logic signed [GW+D_OP_W-1:0]  d_prod;
    logic signed [IACC_W-1:0]     i_acc;
    logic signed [DW-1:0]         n_isum;
    logic signed [SUM_W-1:0]      sum;
    logic signed [DW-1:0]         drive;

    always_comb begin
        err    = EW'(i_in.setpoint) - EW'(i_in.measured);
        abs_ms = i_in.measured[DW-1] ? -EW'(i_in.measured) : EW'(i_in.measured);
        active = abs_ms <= {1'b0, i_cfg.integral_band};
        diff1  = P_OP_W'(err) - P_OP_W'(r_prev_err);
        diff2  = D_OP_W'(err) - (D_OP_W'(r_prev_err) <<< 1) + D_OP_W'(r_pprev_err);
        if (i_cfg.mode == MODE_INCREMENTAL) begin
            p_opnd = diff1;
            d_opnd = diff2;
        end else begin
            p_opnd = P_OP_W'(err);
            d_opnd = D_OP_W'(diff1);
        end
        p_prod = i_cfg.kp_gain * p_opnd;
        i_prod = i_cfg.ki_gain * err;
        d_prod = i_cfg.kd_gain * d_opnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_pprev_err <= '0;
        end else if (i_ctl.s1_adv) begin
            r_prev_err <= err;
            if (i_cfg.mode == MODE_INCREMENTAL) begin
                r_pprev_err <= r_prev_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_adv) begin
            r_p      <= p_prod[GW+P_OP_W-1:FRAC];
            r_i      <= i_prod[GW+EW-1:FRAC];
            r_d      <= d_prod[GW+D_OP_W-1:FRAC];
            r_active <= active;
        end
    end

    always_comb begin
        if (i_cfg.mode == MODE_INCREMENTAL) begin
            i_acc = IACC_W'(r_i);
        end else begin
            i_acc = IACC_W'(r_i) + IACC_W'(r_isum);
        end
        n_isum = r_active ? clamp_sym(SUM_W'(i_acc), i_cfg.integral_limit) : '0;
        sum    = SUM_W'(r_p) + SUM_W'(n_isum) + SUM_W'(r_d);
        drive  = clamp_sym(sum, i_cfg.output_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
        end else if (i_ctl.s2_adv) begin
            r_isum <= n_isum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_adv) begin
            r_out.drive         <= drive;
            r_out.integral_term <= n_isum;
        end
    end

    assign o_out = r_out;

endmodule

/* hw/rtl/pid_positional_incremental_core.sv */
// A sample moves from the input register through the stage-one registers to the output register.
// Throughput: one sample per cycle, sustained whenever the output is not stalled.
// The error registers and the integral sum carry state from one sample to the next.
// Reset clears the pipeline valids, both stored errors and the integral sum,
// and returns every configuration register to its default value.
// ============================================================================
// PID controller core, positional and incremental
// Input register, two compute stages and an output register with flow control.
// ============================================================================
`include "pid_positional_incremental_core_defines.svh"

module pid_positional_incremental_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  pidpi_pkg::t_in              i_in,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output pidpi_pkg::t_out             o_out,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_we,
    input  logic [pidpi_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [pidpi_pkg::CFG_W-1:0] i_cfg_wdata
);
    import pidpi_pkg::*;

    t_cfg cfg;
    t_ctl ctl;
    t_in  r_in;
    logic r_in_v;
    logic r_s1_v;
    logic r_out_v;
    logic n_in_v;
    logic n_s1_v;
    logic n_out_v;
    logic in_acc;
    logic out_free;

    logic signed [DW-1:0] ilim_s;
    logic signed [DW-1:0] olim_s;
    logic                 int_ok;
    logic                 drive_ok;

    pidpi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    always_comb begin
        out_free   = !r_out_v || !i_out_stall;
        ctl.s2_adv = r_s1_v && out_free;
        ctl.s1_adv = r_in_v && (!r_s1_v || ctl.s2_adv);
        o_in_stall = r_in_v && !ctl.s1_adv;
        in_acc     = i_in_valid && !o_in_stall;
        n_in_v     = in_acc || (r_in_v && !ctl.s1_adv);
        n_s1_v     = ctl.s1_adv || (r_s1_v && !ctl.s2_adv);
        n_out_v    = ctl.s2_adv || (r_out_v && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    pidpi_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctl   (ctl),
        .i_in    (r_in),
        .o_out   (o_out)
    );

    assign o_out_valid = r_out_v;

    assign ilim_s = $signed({1'b0, cfg.integral_limit});
    assign olim_s = $signed({1'b0, cfg.output_limit});

    assign int_ok   = !r_out_v ||
                      (o_out.integral_term <= ilim_s && o_out.integral_term >= -ilim_s);
    assign drive_ok = !r_out_v || (o_out.drive <= olim_s && o_out.drive >= -olim_s);

    `PIDPI_ASSERT_HOLDS(a_int_within_limit, i_clk, i_rst_n, int_ok, "integral term beyond limit")
    `PIDPI_ASSERT_HOLDS(a_drive_within_limit, i_clk, i_rst_n, drive_ok, "drive beyond limit")
    `PIDPI_ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n, in_acc, r_in_v, "input transfer lost")
    `PIDPI_ASSERT_NEXT(a_stage_fills_output, i_clk, i_rst_n, ctl.s2_adv, r_out_v, "result lost")

endmodule
